[design/sgi_pkg.sv]
// Package for the segment intersection unit: widths, status codes,
// register indexes and the transaction payload types.
// Depends on nothing.
package sgi_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int CrossW = ProdW + 1;
  localparam int LoW    = (CrossW + 1) / 2;
  localparam int HiW    = CrossW - LoW;
  localparam int QuoW   = CoordW + 4;
  localparam int NumW   = CrossW + QuoW + 1;
  localparam int PtW    = QuoW + 3;
  localparam int ThrW   = 32;
  localparam int TolW   = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgW   = 32;

  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_TOLERANCE = 1'd1;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CoordW-1:0] seg_a_start_x;
    logic signed [CoordW-1:0] seg_a_start_y;
    logic signed [CoordW-1:0] seg_a_end_x;
    logic signed [CoordW-1:0] seg_a_end_y;
    logic signed [CoordW-1:0] seg_b_start_x;
    logic signed [CoordW-1:0] seg_b_start_y;
    logic signed [CoordW-1:0] seg_b_end_x;
    logic signed [CoordW-1:0] seg_b_end_y;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic signed [CoordW-1:0] cross_x;
    logic signed [CoordW-1:0] cross_y;
  } out_t;

  // Values that ride along with an item through every stage.
  typedef struct packed {
    logic                     par;
    logic                     sx;
    logic                     sy;
    logic signed [CoordW-1:0] c0;
    logic signed [CoordW-1:0] c1;
    logic signed [CoordW-1:0] axlo;
    logic signed [CoordW-1:0] axhi;
    logic signed [CoordW-1:0] aylo;
    logic signed [CoordW-1:0] ayhi;
    logic signed [CoordW-1:0] bxlo;
    logic signed [CoordW-1:0] bxhi;
    logic signed [CoordW-1:0] bylo;
    logic signed [CoordW-1:0] byhi;
  } side_t;

endpackage

[design/segment_intersection_unit.sv]
// Segment intersection unit: crossing point of two 2-D segments, with a
// parallel test and a bounding box test. Uses sgi_pkg.
// Accepts one transaction per cycle unless a waiting result is not taken.
// The depth is set by the restoring divider, one quotient bit per stage (36 stages).
// The whole pipeline advances together; it holds while a result waits.
// Reset (synchronous, active low) empties the pipeline and loads the default
// threshold of 1 and tolerance of 655.
module segment_intersection_unit import sgi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CfgW-1:0]    cfg_data
);

  // Configuration registers.
  logic [ThrW-1:0] thr_r;
  logic [TolW-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrW'(1);
      tol_r <= TolW'(655);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_THRESHOLD: thr_r <= cfg_data[ThrW-1:0];
        REG_TOLERANCE: tol_r <= cfg_data[TolW-1:0];
        default: ;
      endcase
    end
  end

  // All stages move together whenever the output register is free or is
  // being emptied in this cycle. A bubble simply travels as an invalid stage.
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage 1: direction and offset vectors, box bounds.
  logic signed [DiffW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, ox_r, oy_r;
  logic signed [DiffW-1:0] d1x_nxt, d1y_nxt, d2x_nxt, d2y_nxt, ox_nxt, oy_nxt;
  side_t s1_r, s1_nxt;

  always_comb begin
    d1x_nxt = DiffW'(in_data.seg_a_end_x) - DiffW'(in_data.seg_a_start_x);
    d1y_nxt = DiffW'(in_data.seg_a_end_y) - DiffW'(in_data.seg_a_start_y);
    d2x_nxt = DiffW'(in_data.seg_b_end_x) - DiffW'(in_data.seg_b_start_x);
    d2y_nxt = DiffW'(in_data.seg_b_end_y) - DiffW'(in_data.seg_b_start_y);
    ox_nxt  = DiffW'(in_data.seg_b_start_x) - DiffW'(in_data.seg_a_start_x);
    oy_nxt  = DiffW'(in_data.seg_b_start_y) - DiffW'(in_data.seg_a_start_y);
    s1_nxt      = '0;
    s1_nxt.c0   = in_data.seg_a_start_x;
    s1_nxt.c1   = in_data.seg_a_start_y;
    s1_nxt.axlo = (in_data.seg_a_start_x < in_data.seg_a_end_x) ?
                  in_data.seg_a_start_x : in_data.seg_a_end_x;
    s1_nxt.axhi = (in_data.seg_a_start_x < in_data.seg_a_end_x) ?
                  in_data.seg_a_end_x : in_data.seg_a_start_x;
    s1_nxt.aylo = (in_data.seg_a_start_y < in_data.seg_a_end_y) ?
                  in_data.seg_a_start_y : in_data.seg_a_end_y;
    s1_nxt.ayhi = (in_data.seg_a_start_y < in_data.seg_a_end_y) ?
                  in_data.seg_a_end_y : in_data.seg_a_start_y;
    s1_nxt.bxlo = (in_data.seg_b_start_x < in_data.seg_b_end_x) ?
                  in_data.seg_b_start_x : in_data.seg_b_end_x;
    s1_nxt.bxhi = (in_data.seg_b_start_x < in_data.seg_b_end_x) ?
                  in_data.seg_b_end_x : in_data.seg_b_start_x;
    s1_nxt.bylo = (in_data.seg_b_start_y < in_data.seg_b_end_y) ?
                  in_data.seg_b_start_y : in_data.seg_b_end_y;
    s1_nxt.byhi = (in_data.seg_b_start_y < in_data.seg_b_end_y) ?
                  in_data.seg_b_end_y : in_data.seg_b_start_y;
  end

  // Stage 2: the four exact products of the two cross products.
  logic signed [ProdW-1:0] m1_r, m2_r, m3_r, m4_r, m1_nxt, m2_nxt, m3_nxt, m4_nxt;
  logic signed [DiffW-1:0] e1x_r, e1y_r;
  side_t s2_r;

  always_comb begin
    m1_nxt = ProdW'(d1x_r) * ProdW'(d2y_r);
    m2_nxt = ProdW'(d1y_r) * ProdW'(d2x_r);
    m3_nxt = ProdW'(ox_r) * ProdW'(d2y_r);
    m4_nxt = ProdW'(oy_r) * ProdW'(d2x_r);
  end

  // Stage 3: cross = dA x dB and num = off x dB.
  logic signed [CrossW-1:0] cr_r, num_r, cr_nxt, num_nxt;
  logic signed [DiffW-1:0]  e2x_r, e2y_r;
  side_t s3_r;

  always_comb begin
    cr_nxt  = CrossW'(m1_r) - CrossW'(m2_r);
    num_nxt = CrossW'(m3_r) - CrossW'(m4_r);
  end

  // Stage 4: magnitudes and result signs, so the divider works unsigned.
  logic [CrossW-1:0] crm_r, numm_r, crm_nxt, numm_nxt;
  logic [DiffW-1:0]  axm_r, aym_r, axm_nxt, aym_nxt;
  side_t s4_r, s4_nxt;

  always_comb begin
    crm_nxt  = cr_r[CrossW-1] ? CrossW'(-cr_r) : CrossW'(cr_r);
    numm_nxt = num_r[CrossW-1] ? CrossW'(-num_r) : CrossW'(num_r);
    axm_nxt  = e2x_r[DiffW-1] ? DiffW'(-e2x_r) : DiffW'(e2x_r);
    aym_nxt  = e2y_r[DiffW-1] ? DiffW'(-e2y_r) : DiffW'(e2y_r);
    s4_nxt    = s3_r;
    s4_nxt.sx = e2x_r[DiffW-1] ^ num_r[CrossW-1] ^ cr_r[CrossW-1];
    s4_nxt.sy = e2y_r[DiffW-1] ^ num_r[CrossW-1] ^ cr_r[CrossW-1];
  end

  // Stage 5: split products |dA| * |num|, and the parallel decision.
  logic [DiffW+LoW-1:0] pxl_r, pyl_r, pxl_nxt, pyl_nxt;
  logic [DiffW+HiW-1:0] pxh_r, pyh_r, pxh_nxt, pyh_nxt;
  logic [CrossW-1:0]    crm5_r;
  side_t s5_r, s5_nxt;

  always_comb begin
    pxl_nxt = (DiffW+LoW)'(axm_r) * (DiffW+LoW)'(numm_r[LoW-1:0]);
    pxh_nxt = (DiffW+HiW)'(axm_r) * (DiffW+HiW)'(numm_r[CrossW-1:LoW]);
    pyl_nxt = (DiffW+LoW)'(aym_r) * (DiffW+LoW)'(numm_r[LoW-1:0]);
    pyh_nxt = (DiffW+HiW)'(aym_r) * (DiffW+HiW)'(numm_r[CrossW-1:LoW]);
    s5_nxt     = s4_r;
    // A zero cross product is parallel even with a zero threshold.
    s5_nxt.par = (crm_r == '0) || (crm_r < CrossW'(thr_r));
  end

  // Stage 6: dividend with half the divisor added, for round to nearest.
  logic [NumW-1:0]   nx_r, ny_r, nx_nxt, ny_nxt;
  logic [CrossW-1:0] crm6_r;
  side_t s6_r;

  always_comb begin
    nx_nxt = (NumW'(pxh_r) << LoW) + NumW'(pxl_r) + NumW'(crm5_r >> 1);
    ny_nxt = (NumW'(pyh_r) << LoW) + NumW'(pyl_r) + NumW'(crm5_r >> 1);
  end

  // Divider: entry 0 checks for a quotient of more than QuoW bits (that point
  // lies far outside every box and saturates). Entries 1 to QuoW each
  // resolve one quotient bit, most significant first.
  logic [NumW-1:0]   rx_r [QuoW+1];
  logic [NumW-1:0]   ry_r [QuoW+1];
  logic [QuoW-1:0]   qx_r [QuoW+1];
  logic [QuoW-1:0]   qy_r [QuoW+1];
  logic              vx_r [QuoW+1];
  logic              vy_r [QuoW+1];
  logic [CrossW-1:0] dv_r [QuoW+1];
  side_t             sd_r [QuoW+1];
  logic [NumW-1:0]   rx_nxt [QuoW+1];
  logic [NumW-1:0]   ry_nxt [QuoW+1];
  logic [QuoW-1:0]   qx_nxt [QuoW+1];
  logic [QuoW-1:0]   qy_nxt [QuoW+1];
  logic              vx_nxt, vy_nxt;

  always_comb begin
    logic [NumW-1:0] shd;
    shd = '0;
    vx_nxt    = nx_r >= (NumW'(crm6_r) << QuoW);
    vy_nxt    = ny_r >= (NumW'(crm6_r) << QuoW);
    rx_nxt[0] = nx_r;
    ry_nxt[0] = ny_r;
    qx_nxt[0] = '0;
    qy_nxt[0] = '0;
    for (int k = 1; k <= QuoW; k++) begin
      shd = NumW'(dv_r[k-1]) << (QuoW - k);
      if (rx_r[k-1] >= shd) begin
        rx_nxt[k] = rx_r[k-1] - shd;
        qx_nxt[k] = {qx_r[k-1][QuoW-2:0], 1'b1};
      end else begin
        rx_nxt[k] = rx_r[k-1];
        qx_nxt[k] = {qx_r[k-1][QuoW-2:0], 1'b0};
      end
      if (ry_r[k-1] >= shd) begin
        ry_nxt[k] = ry_r[k-1] - shd;
        qy_nxt[k] = {qy_r[k-1][QuoW-2:0], 1'b1};
      end else begin
        ry_nxt[k] = ry_r[k-1];
        qy_nxt[k] = {qy_r[k-1][QuoW-2:0], 1'b0};
      end
    end
  end

  // Final stage 1: apply the sign to the quotient.
  logic signed [QuoW:0] sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic                 fvx1_r, fvy1_r;
  side_t                f1_r;

  always_comb begin
    sqx_nxt = sd_r[QuoW].sx ? -$signed({1'b0, qx_r[QuoW]}) : $signed({1'b0, qx_r[QuoW]});
    sqy_nxt = sd_r[QuoW].sy ? -$signed({1'b0, qy_r[QuoW]}) : $signed({1'b0, qy_r[QuoW]});
  end

  // Final stage 2: add the start point of segment A.
  logic signed [PtW-1:0] px_r, py_r, px_nxt, py_nxt;
  logic                  fvx2_r, fvy2_r;
  side_t                 f2_r;

  always_comb begin
    px_nxt = PtW'(f1_r.c0) + PtW'(sqx_r);
    py_nxt = PtW'(f1_r.c1) + PtW'(sqy_r);
  end

  // Output stage: box tests against the unsaturated point, then saturation.
  localparam logic signed [PtW-1:0] PMax = {{(PtW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
  localparam logic signed [PtW-1:0] PMin = {{(PtW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};

  out_t out_data_r, out_nxt;

  always_comb begin
    logic signed [PtW:0] tol, pxa, pxs, pya, pys;
    logic                hit;
    logic signed [PtW-1:0] sx, sy;
    tol = $signed({{(PtW+1-TolW){1'b0}}, tol_r});
    pxa = (PtW+1)'(px_r) + tol;
    pxs = (PtW+1)'(px_r) - tol;
    pya = (PtW+1)'(py_r) + tol;
    pys = (PtW+1)'(py_r) - tol;
    hit = !fvx2_r && !fvy2_r &&
          pxa >= (PtW+1)'(f2_r.axlo) && pxs <= (PtW+1)'(f2_r.axhi) &&
          pya >= (PtW+1)'(f2_r.aylo) && pys <= (PtW+1)'(f2_r.ayhi) &&
          pxa >= (PtW+1)'(f2_r.bxlo) && pxs <= (PtW+1)'(f2_r.bxhi) &&
          pya >= (PtW+1)'(f2_r.bylo) && pys <= (PtW+1)'(f2_r.byhi);
    // An oversized quotient dominates the start point, so its sign decides.
    if (fvx2_r)           sx = f2_r.sx ? PMin : PMax;
    else if (px_r > PMax) sx = PMax;
    else if (px_r < PMin) sx = PMin;
    else                  sx = px_r;
    if (fvy2_r)           sy = f2_r.sy ? PMin : PMax;
    else if (py_r > PMax) sy = PMax;
    else if (py_r < PMin) sy = PMin;
    else                  sy = py_r;
    if (f2_r.par) begin
      out_nxt.status  = ST_PARALLEL;
      out_nxt.cross_x = '0;
      out_nxt.cross_y = '0;
    end else begin
      out_nxt.status  = hit ? ST_HIT : ST_OUTSIDE;
      out_nxt.cross_x = sx[CoordW-1:0];
      out_nxt.cross_y = sy[CoordW-1:0];
    end
  end

  // Payload registers, all on the common advance.
  always_ff @(posedge clk) begin
    if (adv) begin
      d1x_r <= d1x_nxt; d1y_r <= d1y_nxt; d2x_r <= d2x_nxt; d2y_r <= d2y_nxt;
      ox_r  <= ox_nxt;  oy_r  <= oy_nxt;  s1_r  <= s1_nxt;
      m1_r  <= m1_nxt;  m2_r  <= m2_nxt;  m3_r  <= m3_nxt;  m4_r  <= m4_nxt;
      e1x_r <= d1x_r;   e1y_r <= d1y_r;   s2_r  <= s1_r;
      cr_r  <= cr_nxt;  num_r <= num_nxt; e2x_r <= e1x_r;   e2y_r <= e1y_r;
      s3_r  <= s2_r;
      crm_r <= crm_nxt; numm_r <= numm_nxt; axm_r <= axm_nxt; aym_r <= aym_nxt;
      s4_r  <= s4_nxt;
      pxl_r <= pxl_nxt; pxh_r <= pxh_nxt; pyl_r <= pyl_nxt; pyh_r <= pyh_nxt;
      crm5_r <= crm_r;  s5_r  <= s5_nxt;
      nx_r  <= nx_nxt;  ny_r  <= ny_nxt;  crm6_r <= crm5_r; s6_r <= s5_r;
      rx_r[0] <= rx_nxt[0]; ry_r[0] <= ry_nxt[0];
      qx_r[0] <= qx_nxt[0]; qy_r[0] <= qy_nxt[0];
      vx_r[0] <= vx_nxt;    vy_r[0] <= vy_nxt;
      dv_r[0] <= crm6_r;    sd_r[0] <= s6_r;
      for (int k = 1; k <= QuoW; k++) begin
        rx_r[k] <= rx_nxt[k]; ry_r[k] <= ry_nxt[k];
        qx_r[k] <= qx_nxt[k]; qy_r[k] <= qy_nxt[k];
        vx_r[k] <= vx_r[k-1]; vy_r[k] <= vy_r[k-1];
        dv_r[k] <= dv_r[k-1]; sd_r[k] <= sd_r[k-1];
      end
      sqx_r <= sqx_nxt; sqy_r <= sqy_nxt;
      fvx1_r <= vx_r[QuoW]; fvy1_r <= vy_r[QuoW]; f1_r <= sd_r[QuoW];
      px_r <= px_nxt; py_r <= py_nxt;
      fvx2_r <= fvx1_r; fvy2_r <= fvy1_r; f2_r <= f1_r;
      out_data_r <= out_nxt;
    end
  end

  // Valid bits: six front stages, the divider entries, two final stages
  // and the output register.
  localparam int NStg = 6 + (QuoW + 1) + 2;
  logic [NStg-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NStg-2:0], in_valid};
      out_valid_r <= vld_r[NStg-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/sgi_checker.sv]
// Checker for the segment intersection unit: watches both channels, predicts
// each result with an exact wide-integer model and compares it. Uses sgi_pkg.
module sgi_checker import sgi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_t                in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_t               out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CfgW-1:0]    cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] big_t;

  logic [ThrW-1:0] thr_q;
  logic [TolW-1:0] tol_q;
  out_t            expected_q[$];

  function automatic big_t round_quot(big_t a, big_t b);
    big_t ma, mb, q;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    q  = (ma + (mb >>> 1)) / mb;
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  function automatic bit within_box(big_t p, big_t e0, big_t e1, big_t tol);
    big_t lo, hi;
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    return (p + tol >= lo) && (p - tol <= hi);
  endfunction

  function automatic logic [CoordW-1:0] clamp_coord(big_t p);
    big_t mx, mn;
    mx = (big_t'(1) <<< (CoordW - 1)) - 1;
    mn = -(big_t'(1) <<< (CoordW - 1));
    if (p > mx) p = mx;
    if (p < mn) p = mn;
    return p[CoordW-1:0];
  endfunction

  function automatic out_t predict_crossing(in_t s);
    big_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    big_t dax, day, dbx, dby, ox, oy, cr, num, px, py, tol, acr;
    out_t r;
    ax0 = big_t'(s.seg_a_start_x); ay0 = big_t'(s.seg_a_start_y);
    ax1 = big_t'(s.seg_a_end_x);   ay1 = big_t'(s.seg_a_end_y);
    bx0 = big_t'(s.seg_b_start_x); by0 = big_t'(s.seg_b_start_y);
    bx1 = big_t'(s.seg_b_end_x);   by1 = big_t'(s.seg_b_end_y);
    dax = ax1 - ax0; day = ay1 - ay0;
    dbx = bx1 - bx0; dby = by1 - by0;
    ox = bx0 - ax0; oy = by0 - ay0;
    cr = dax * dby - day * dbx;
    acr = (cr < 0) ? -cr : cr;
    if (cr == 0 || acr < big_t'({1'b0, thr_q})) begin
      r.status = ST_PARALLEL;
      r.cross_x = '0;
      r.cross_y = '0;
      return r;
    end
    num = ox * dby - oy * dbx;
    px = ax0 + round_quot(dax * num, cr);
    py = ay0 + round_quot(day * num, cr);
    tol = big_t'({1'b0, tol_q});
    r.status = (within_box(px, ax0, ax1, tol) && within_box(py, ay0, ay1, tol) &&
                within_box(px, bx0, bx1, tol) && within_box(py, by0, by1, tol))
               ? ST_HIT : ST_OUTSIDE;
    r.cross_x = clamp_coord(px);
    r.cross_y = clamp_coord(py);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      thr_q <= ThrW'(1);
      tol_q <= TolW'(655);
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_THRESHOLD) thr_q <= cfg_data[ThrW-1:0];
        else if (cfg_idx == REG_TOLERANCE) tol_q <= cfg_data[TolW-1:0];
      end
      if (in_valid && in_ready) expected_q.push_back(predict_crossing(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d x=%0d y=%0d", $time,
                   out_data.status, out_data.cross_x, out_data.cross_y);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_data !== want) begin
            $display("%0t: mismatch expected status=%0d x=%0d y=%0d, got status=%0d x=%0d y=%0d",
                     $time, want.status, want.cross_x, want.cross_y,
                     out_data.status, out_data.cross_x, out_data.cross_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/tb_segment_intersection_unit.sv]
// Top of the segment intersection testbench: clock, reset, configuration
// phases and segment-pair stimulus. Uses sgi_pkg and sgi_checker.
module tb_segment_intersection_unit import sgi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 46;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  longint cycle_count = 0;
  bit stim_done = 1'b0;

  always #6 clk = ~clk;

  segment_intersection_unit dut (.*);

  sgi_checker checker_i (.*);

  // The run is ended here if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The result side stalls for a random gap before each transaction, or not at all
  // when the drawn gap is zero.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Send one transaction after a random gap. Valid stays high across
  // back-to-back transactions when the drawn gap is zero.
  task automatic send_pair(in_t item, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until all results are back, plus the pipeline depth.
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      default: return 32'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // Mostly well-behaved pairs around the origin, some full-range noise,
  // and some deliberately parallel segments or vertical second segments.
  function automatic in_t random_pair();
    in_t p;
    int mode, kind;
    logic [31:0] dx, dy;
    mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
    p.seg_a_start_x = rand_coord(mode); p.seg_a_start_y = rand_coord(mode);
    p.seg_a_end_x   = rand_coord(mode); p.seg_a_end_y   = rand_coord(mode);
    p.seg_b_start_x = rand_coord(mode); p.seg_b_start_y = rand_coord(mode);
    p.seg_b_end_x   = rand_coord(mode); p.seg_b_end_y   = rand_coord(mode);
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // Same direction on both segments.
      dx = p.seg_a_end_x - p.seg_a_start_x;
      dy = p.seg_a_end_y - p.seg_a_start_y;
      p.seg_b_end_x = p.seg_b_start_x + dx;
      p.seg_b_end_y = p.seg_b_start_y + dy;
    end else if (kind == 1) begin
      p.seg_b_end_x = p.seg_b_start_x;
    end
    return p;
  endfunction

  function automatic in_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                    int bx0, int by0, int bx1, int by1);
    in_t p;
    p.seg_a_start_x = ax0; p.seg_a_start_y = ay0;
    p.seg_a_end_x = ax1;   p.seg_a_end_y = ay1;
    p.seg_b_start_x = bx0; p.seg_b_start_y = by0;
    p.seg_b_end_x = bx1;   p.seg_b_end_y = by1;
    return p;
  endfunction

  initial begin
    localparam int One = 1 << 16;
    localparam int Mx = 32'h7fffffff;
    localparam int Mn = 32'h80000000;
    int n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset defaults: a clean hit, parallel and collinear
    // segments, a zero cross product, a crossing outside, degenerate boxes
    // and the extremes of the coordinate range.
    send_pair(make_pair(-One, 0, One, 0, 0, -One, 0, One));
    send_pair(make_pair(0, 0, One, One, 0, One, One, 2 * One));
    send_pair(make_pair(0, 0, One, 0, 2 * One, 0, 3 * One, 0));
    send_pair(make_pair(0, 0, One, 0, 5 * One, -One, 5 * One, One));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, One, One));
    send_pair(make_pair(0, -One, 0, One, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
    send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 1));
    send_pair(make_pair(Mn, Mn, Mx, Mx, Mn, Mx, Mx, Mn));
    send_pair(make_pair(Mx, Mx, Mn, Mn, Mx, Mn, Mn, Mx));
    send_pair(make_pair(Mn, 0, Mn + 1, 1, Mx, 0, Mx, 1));
    send_pair(make_pair(Mn, Mn, Mn, Mn, Mx, Mx, Mx, Mx));
    send_pair(make_pair(0, 0, 1, 0, Mx, Mn, Mx - 1, Mx));
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    // Just outside the box by more and by less than the tolerance.
    send_pair(make_pair(0, 0, One, 0, One + 600, -One, One + 600, One));
    send_pair(make_pair(0, 0, One, 0, One + 700, -One, One + 700, One));
    drain_pipe();

    // Several register settings, extremes among them, each with a random phase.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_THRESHOLD, 32'd0); write_reg(REG_TOLERANCE, 32'd0); end
        1: begin write_reg(REG_THRESHOLD, 32'hffffffff); write_reg(REG_TOLERANCE, 32'hffff); end
        2: begin write_reg(REG_THRESHOLD, 32'd1); write_reg(REG_TOLERANCE, 32'd655); end
        3: begin write_reg(REG_THRESHOLD, $urandom()); write_reg(REG_TOLERANCE, $urandom()); end
        4: begin write_reg(REG_THRESHOLD, 32'h10000); write_reg(REG_TOLERANCE, 32'd1); end
        default: begin
          write_reg(REG_THRESHOLD, 32'd1 << $urandom_range(0, 31));
          write_reg(REG_TOLERANCE, $urandom_range(0, 4000));
        end
      endcase
      n = (ph == 1) ? 60 : 130;
      for (int i = 0; i < n; i++) begin
        send_pair(random_pair(), (i % 40) >= 30);
        // Once per phase the sender holds off until every result is back.
        if (i == n / 2) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
      drain_pipe();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

[files.f]
design/sgi_pkg.sv
design/segment_intersection_unit.sv
tb/sgi_checker.sv
tb/tb_segment_intersection_unit.sv
